/* src/dec_pkg.sv */
// ----------------------------------------------------------------------------
// dec_pkg
// Shared constants, types and register indexes of the disparity error compare
// ----------------------------------------------------------------------------
package dec_pkg;

  localparam int unsigned FramePixelsLog2 = 20;
  localparam int unsigned DispBits        = 16;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned ErrW    = 16;
  localparam int unsigned CapW    = 16;
  localparam int unsigned GainW   = 24;
  localparam int unsigned CountW  = 21;
  localparam int unsigned TotalW  = 36;
  localparam int unsigned ProdW   = ErrW + GainW;
  localparam int unsigned DispW   = (DispBits < FieldW) ? DispBits : FieldW;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 104;

  localparam logic [CountW-1:0] CountLimit =
    (FramePixelsLog2 < CountW) ? CountW'(64'd1 << FramePixelsLog2) : '1;

  localparam logic [63:0] TotalRaw   = 64'd65535 << FramePixelsLog2;
  localparam logic [63:0] TotalField = 64'h0000_000F_FFFF_FFFF;
  localparam logic [TotalW-1:0] TotalLimit =
    (TotalRaw > TotalField) ? TotalField[TotalW-1:0] : TotalRaw[TotalW-1:0];

  localparam logic [0:0] RegErrorCap = 1'b0;
  localparam logic [0:0] RegGrayGain = 1'b1;

  localparam logic [CapW-1:0]  CapReset  = 16'd16;
  localparam logic [GainW-1:0] GainReset = 24'd1044480;

  typedef enum logic [2:0] {
    PixNoTruthGuess,
    PixNoTruth,
    PixMissGuess,
    PixInlier,
    PixOutlier
  } pix_kind_e;

  typedef struct packed {
    pix_kind_e       kind;
    logic [ErrW-1:0] err;
    logic            last;
  } pix_class_t;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [CountW-1:0] inliers;
    logic [CountW-1:0] outliers;
    logic [TotalW-1:0] total;
    logic              done;
  } pix_result_t;

endpackage

/* src/dec_classify.sv */
// ----------------------------------------------------------------------------
// dec_classify
// Absolute disparity error and pixel class from one registered input beat
// ----------------------------------------------------------------------------
module dec_classify (
  input  logic [dec_pkg::FieldW-1:0] truth_i,
  input  logic [dec_pkg::FieldW-1:0] guess_i,
  input  logic                       truth_ok_i,
  input  logic                       guess_ok_i,
  input  logic                       not_finite_i,
  input  logic                       frame_end_i,
  input  logic [dec_pkg::CapW-1:0]   error_cap_i,
  output dec_pkg::pix_class_t        class_o
);

  logic signed [dec_pkg::FieldW:0]   truth_s;
  logic signed [dec_pkg::FieldW:0]   guess_s;
  logic signed [dec_pkg::FieldW+1:0] diff;
  logic        [dec_pkg::FieldW+1:0] diff_abs;
  logic        [dec_pkg::ErrW-1:0]   err;

  // take the low disparity bits as two's complement; zero-extend when DispBits > FieldW
  if (dec_pkg::DispBits > dec_pkg::FieldW) begin : g_wide
    assign truth_s = $signed({1'b0, truth_i});
    assign guess_s = $signed({1'b0, guess_i});
  end else begin : g_narrow
    assign truth_s = (dec_pkg::FieldW + 1)'($signed(truth_i[dec_pkg::DispW-1:0]));
    assign guess_s = (dec_pkg::FieldW + 1)'($signed(guess_i[dec_pkg::DispW-1:0]));
  end

  assign diff     = (dec_pkg::FieldW + 2)'(truth_s) - (dec_pkg::FieldW + 2)'(guess_s);
  assign diff_abs = diff[dec_pkg::FieldW+1] ? (dec_pkg::FieldW + 2)'(-diff)
                                            : (dec_pkg::FieldW + 2)'(diff);
  assign err      = diff_abs[dec_pkg::ErrW-1:0];

  always_comb begin
    class_o.last = frame_end_i;
    class_o.err  = err;
    if (!truth_ok_i) begin
      class_o.kind = guess_ok_i ? dec_pkg::PixNoTruthGuess : dec_pkg::PixNoTruth;
    end else if (!guess_ok_i) begin
      class_o.kind = dec_pkg::PixMissGuess;
    end else if (not_finite_i || (err > error_cap_i)) begin
      class_o.kind = dec_pkg::PixOutlier;
      class_o.err  = error_cap_i;
    end else begin
      class_o.kind = dec_pkg::PixInlier;
    end
  end

endmodule

/* src/dec_accum.sv */
// ----------------------------------------------------------------------------
// dec_accum
// Grey scaling, saturating frame statistics and the result register
// ----------------------------------------------------------------------------
module dec_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  dec_pkg::pix_class_t       class_i,
  input  logic [dec_pkg::GainW-1:0] gray_gain_i,
  output dec_pkg::pix_result_t      result_o
);

  logic [dec_pkg::CountW-1:0] inl_q, inl_d, inl_new;
  logic [dec_pkg::CountW-1:0] outl_q, outl_d, outl_new;
  logic [dec_pkg::TotalW-1:0] total_q, total_d, total_new;
  logic [dec_pkg::TotalW:0]   total_sum;
  logic [dec_pkg::ProdW-1:0]  prod;
  logic [7:0]                 grey;
  dec_pkg::pix_result_t       result_q, result_d;

  assign prod = dec_pkg::ProdW'(class_i.err) * dec_pkg::ProdW'(gray_gain_i);
  assign grey = (|prod[dec_pkg::ProdW-1:24]) ? 8'hFF : prod[23:16];

  assign total_sum = (dec_pkg::TotalW + 1)'(total_q) + (dec_pkg::TotalW + 1)'(class_i.err);

  always_comb begin
    inl_new   = inl_q;
    outl_new  = outl_q;
    total_new = total_q;
    case (class_i.kind)
      dec_pkg::PixMissGuess, dec_pkg::PixOutlier: begin
        if (outl_q < dec_pkg::CountLimit) outl_new = outl_q + 1'b1;
      end
      dec_pkg::PixInlier: begin
        if (inl_q < dec_pkg::CountLimit) inl_new = inl_q + 1'b1;
        total_new = (total_sum > {1'b0, dec_pkg::TotalLimit}) ? dec_pkg::TotalLimit
                                                              : total_sum[dec_pkg::TotalW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    result_d.inliers  = inl_new;
    result_d.outliers = outl_new;
    result_d.total    = total_new;
    result_d.done     = class_i.last;
    case (class_i.kind)
      dec_pkg::PixNoTruthGuess: begin
        result_d.red = 8'h00; result_d.green = 8'hFF; result_d.blue = 8'h00;
      end
      dec_pkg::PixNoTruth: begin
        result_d.red = 8'h00; result_d.green = 8'h00; result_d.blue = 8'hFF;
      end
      dec_pkg::PixMissGuess: begin
        result_d.red = 8'hFF; result_d.green = 8'h00; result_d.blue = 8'h00;
      end
      default: begin
        result_d.red = grey; result_d.green = grey; result_d.blue = grey;
      end
    endcase
  end

  // statistics clear after the last pixel of a frame
  assign inl_d   = class_i.last ? '0 : inl_new;
  assign outl_d  = class_i.last ? '0 : outl_new;
  assign total_d = class_i.last ? '0 : total_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inl_q   <= '0;
      outl_q  <= '0;
      total_q <= '0;
    end else if (step_i) begin
      inl_q   <= inl_d;
      outl_q  <= outl_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* src/disparity_error_compare.sv */
// ----------------------------------------------------------------------------
// disparity_error_compare
// Per-pixel disparity error colouring with running inlier/outlier statistics
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata truth,guess; tuser flags; tlast
//  m_axis    out  tvalid/tready          tdata colour and totals; tlast done
//  cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
//  one beat per cycle in and out while m_axis is not stalled; a beat passes
//  the input register, class register and result register in that order
//  m_axis stall freezes all three stages; s_axis_tready is low only then
//  reset clears the valid bits and statistics and loads the config registers; no clearing pass
// ----------------------------------------------------------------------------
module disparity_error_compare (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dec_pkg::InDataW-1:0]  s_axis_tdata,  // truth_value, guess_value
  input  logic [dec_pkg::InUserW-1:0]  s_axis_tuser,  // truth_ok, guess_ok, not_finite
  input  logic                         s_axis_tlast,  // frame_end

  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dec_pkg::OutDataW-1:0] m_axis_tdata,  // red, green, blue, inliers_so_far,
                                                      // outliers_so_far, inlier_error_total
  output logic                         m_axis_tlast,  // frame_done

  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [dec_pkg::GainW-1:0]    cfg_data_i
);

  logic                        step;
  logic                        v1_q, v2_q, v3_q;
  logic [dec_pkg::FieldW-1:0]  truth_q, guess_q;
  logic                        truth_ok_q, guess_ok_q, not_finite_q, last_q;
  logic [dec_pkg::CapW-1:0]    cap_q;
  logic [dec_pkg::GainW-1:0]   gain_q;
  dec_pkg::pix_class_t         class_d, class_q;
  dec_pkg::pix_result_t        result;

  assign step          = !v3_q || m_axis_tready;
  assign s_axis_tready = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= dec_pkg::CapReset;
      gain_q <= dec_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dec_pkg::RegErrorCap: cap_q  <= cfg_data_i[dec_pkg::CapW-1:0];
        dec_pkg::RegGrayGain: gain_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (step) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      truth_q      <= s_axis_tdata[15:0];
      guess_q      <= s_axis_tdata[31:16];
      truth_ok_q   <= s_axis_tuser[0];
      guess_ok_q   <= s_axis_tuser[1];
      not_finite_q <= s_axis_tuser[2];
      last_q       <= s_axis_tlast;
      class_q      <= class_d;
    end
  end

  dec_classify u_classify (
    .truth_i      (truth_q),
    .guess_i      (guess_q),
    .truth_ok_i   (truth_ok_q),
    .guess_ok_i   (guess_ok_q),
    .not_finite_i (not_finite_q),
    .frame_end_i  (last_q),
    .error_cap_i  (cap_q),
    .class_o      (class_d)
  );

  dec_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step && v2_q),
    .class_i     (class_q),
    .gray_gain_i (gain_q),
    .result_o    (result)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {2'b00, result.total, result.outliers, result.inliers,
                          result.blue, result.green, result.red};
  assign m_axis_tlast  = result.done;

endmodule

/* src/dec_checker.sv */
// ----------------------------------------------------------------------------
// dec_checker
// Port-level checks of the disparity error compare
// ----------------------------------------------------------------------------
module dec_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dec_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  logic [7:0]                 red, green, blue;
  logic [dec_pkg::CountW-1:0] inliers, outliers;
  logic [dec_pkg::TotalW-1:0] total;

  assign red      = m_axis_tdata[7:0];
  assign green    = m_axis_tdata[15:8];
  assign blue     = m_axis_tdata[23:16];
  assign inliers  = m_axis_tdata[44:24];
  assign outliers = m_axis_tdata[65:45];
  assign total    = m_axis_tdata[101:66];

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // non-grey pixels are pure red, green or blue
  a_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !(red == green && green == blue)) |->
      ((red == 8'hFF && green == 8'h00 && blue == 8'h00) ||
       (red == 8'h00 && green == 8'hFF && blue == 8'h00) ||
       (red == 8'h00 && green == 8'h00 && blue == 8'hFF)))
    else $error("mixed colour on output");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (inliers <= dec_pkg::CountLimit && outliers <= dec_pkg::CountLimit &&
                       total <= dec_pkg::TotalLimit))
    else $error("statistics above saturation limit");

  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && inliers == '0) |-> (total == '0))
    else $error("error total without inliers");

endmodule

bind disparity_error_compare dec_checker u_dec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
